// ===== hdl/kbd_pkg.sv =====
`default_nettype none

package kbd_pkg;

    localparam int ScanWidth  = 8;
    localparam int AsciiWidth = 7;

    typedef logic [ScanWidth-1:0]  scan_code_t;
    typedef logic [AsciiWidth-1:0] ascii_t;

    localparam scan_code_t KEY_RELEASE_BIT = 8'h80;
    localparam scan_code_t KEY_CAPS        = 8'h3A;
    localparam scan_code_t KEY_LCTRL       = 8'h1D;
    localparam scan_code_t KEY_LSHIFT      = 8'h2A;
    localparam scan_code_t KEY_LALT        = 8'h38;

    localparam ascii_t FILL_CHAR  = 7'h2E;
    localparam ascii_t CTRL_CHAR  = 7'h20;
    localparam ascii_t LOWER_A    = 7'h61;
    localparam ascii_t LOWER_Z    = 7'h7A;
    localparam ascii_t CASE_DELTA = 7'h20;

    typedef struct packed {
        logic caps;
        logic shift;
        logic ctrl;
    } kbd_flags_t;

    typedef struct packed {
        logic   valid;
        ascii_t ch;
    } kbd_result_t;

    function automatic ascii_t plain_char(input logic [6:0] code);
        ascii_t c;
        case (code)
            7'd2:  c = 7'h31;
            7'd3:  c = 7'h32;
            7'd4:  c = 7'h33;
            7'd5:  c = 7'h34;
            7'd6:  c = 7'h35;
            7'd7:  c = 7'h36;
            7'd8:  c = 7'h37;
            7'd9:  c = 7'h38;
            7'd10: c = 7'h39;
            7'd11: c = 7'h30;
            7'd12: c = 7'h2D;
            7'd13: c = 7'h3D;
            7'd14: c = 7'h08;
            7'd16: c = 7'h71;
            7'd17: c = 7'h77;
            7'd18: c = 7'h65;
            7'd19: c = 7'h72;
            7'd20: c = 7'h74;
            7'd21: c = 7'h79;
            7'd22: c = 7'h75;
            7'd23: c = 7'h69;
            7'd24: c = 7'h6F;
            7'd25: c = 7'h70;
            7'd26: c = 7'h5B;
            7'd27: c = 7'h5D;
            7'd28: c = 7'h0A;
            7'd30: c = 7'h61;
            7'd31: c = 7'h73;
            7'd32: c = 7'h64;
            7'd33: c = 7'h66;
            7'd34: c = 7'h67;
            7'd35: c = 7'h68;
            7'd36: c = 7'h6A;
            7'd37: c = 7'h6B;
            7'd38: c = 7'h6C;
            7'd39: c = 7'h3B;
            7'd40: c = 7'h27;
            7'd41: c = 7'h60;
            7'd43: c = 7'h5C;
            7'd44: c = 7'h7A;
            7'd45: c = 7'h78;
            7'd46: c = 7'h63;
            7'd47: c = 7'h76;
            7'd48: c = 7'h62;
            7'd49: c = 7'h6E;
            7'd50: c = 7'h6D;
            7'd51: c = 7'h2C;
            7'd52: c = 7'h2E;
            7'd53: c = 7'h2F;
            7'd55: c = 7'h2A;
            7'd57: c = 7'h20;
            7'd71: c = 7'h37;
            7'd72: c = 7'h38;
            7'd73: c = 7'h39;
            7'd74: c = 7'h34;
            7'd75: c = 7'h35;
            7'd76: c = 7'h36;
            7'd77: c = 7'h31;
            7'd78: c = 7'h32;
            7'd79: c = 7'h33;
            7'd80: c = 7'h30;
            default: c = FILL_CHAR;
        endcase
        return c;
    endfunction

    function automatic ascii_t shift_char(input logic [6:0] code);
        ascii_t c;
        case (code)
            7'd2:  c = 7'h21;
            7'd3:  c = 7'h40;
            7'd4:  c = 7'h23;
            7'd5:  c = 7'h24;
            7'd6:  c = 7'h25;
            7'd7:  c = 7'h5E;
            7'd8:  c = 7'h26;
            7'd9:  c = 7'h2A;
            7'd10: c = 7'h28;
            7'd11: c = 7'h29;
            7'd12: c = 7'h5F;
            7'd13: c = 7'h2B;
            7'd14: c = 7'h08;
            7'd16: c = 7'h51;
            7'd17: c = 7'h57;
            7'd18: c = 7'h45;
            7'd19: c = 7'h52;
            7'd20: c = 7'h54;
            7'd21: c = 7'h59;
            7'd22: c = 7'h55;
            7'd23: c = 7'h49;
            7'd24: c = 7'h4F;
            7'd25: c = 7'h50;
            7'd26: c = 7'h7B;
            7'd27: c = 7'h7D;
            7'd28: c = 7'h0A;
            7'd30: c = 7'h41;
            7'd31: c = 7'h53;
            7'd32: c = 7'h44;
            7'd33: c = 7'h46;
            7'd34: c = 7'h47;
            7'd35: c = 7'h48;
            7'd36: c = 7'h4A;
            7'd37: c = 7'h4B;
            7'd38: c = 7'h4C;
            7'd39: c = 7'h3A;
            7'd40: c = 7'h22;
            7'd41: c = 7'h7E;
            7'd43: c = 7'h7C;
            7'd44: c = 7'h5A;
            7'd45: c = 7'h58;
            7'd46: c = 7'h43;
            7'd47: c = 7'h56;
            7'd48: c = 7'h42;
            7'd49: c = 7'h4E;
            7'd50: c = 7'h4D;
            7'd51: c = 7'h3C;
            7'd52: c = 7'h3E;
            7'd53: c = 7'h3F;
            7'd55: c = 7'h2A;
            7'd57: c = 7'h20;
            7'd71: c = 7'h37;
            7'd72: c = 7'h38;
            7'd73: c = 7'h39;
            7'd74: c = 7'h34;
            7'd75: c = 7'h35;
            7'd76: c = 7'h36;
            7'd77: c = 7'h31;
            7'd78: c = 7'h32;
            7'd79: c = 7'h33;
            7'd80: c = 7'h30;
            default: c = FILL_CHAR;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/kbd_scan_if.sv =====
`default_nettype none

interface kbd_scan_if;
    logic                valid;
    logic                ready;
    kbd_pkg::scan_code_t scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

`default_nettype wire

// ===== hdl/kbd_ascii_if.sv =====
`default_nettype none

interface kbd_ascii_if;
    logic            valid;
    logic            ready;
    kbd_pkg::ascii_t ascii_char;

    modport source (output valid, output ascii_char, input ready);
    modport sink   (input valid, input ascii_char, output ready);
endinterface

`default_nettype wire

// ===== hdl/keyboard_scancode_to_ascii.sv =====
// Channel | Dir | Payload          | Notes
// scan    | in  | scan_code  [7:0] | set-1 byte, bit 7 = release
// ascii   | out | ascii_char [6:0] | one transfer per non-modifier press
//
// One scancode per cycle while no stalled result holds scan; a character is
// valid the cycle after its transfer. Translation is one table lookup plus
// a flag update between the input and the single result register.
// Reset clears the caps, shift and ctrl flags and the result valid flag.
// A stalled result holds; scan stays ready while the result is taken.
`default_nettype none

module keyboard_scancode_to_ascii (
    input  wire logic    clk,
    input  wire logic    rst_n,
    kbd_scan_if.sink     scan,
    kbd_ascii_if.source  ascii
);
    import kbd_pkg::*;

    kbd_flags_t  flags_reg;
    kbd_flags_t  flags_next;
    kbd_result_t xl;
    logic        out_valid_reg;
    logic        out_valid_next;
    ascii_t      out_char_reg;
    logic        in_fire;

    kbd_xlate u_xlate (
        .code       (scan.scan_code),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .result     (xl)
    );

    assign scan.ready = !out_valid_reg || ascii.ready;
    assign in_fire    = scan.valid && scan.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg && !ascii.ready;
        if (in_fire && xl.valid)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
                flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && xl.valid)
            out_char_reg <= xl.ch;
    end

    assign ascii.valid      = out_valid_reg;
    assign ascii.ascii_char = out_char_reg;

    a_rise_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_fire))
        else $error("result appeared without an input transfer");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> scan.ready)
        else $error("input stalled with empty result register");

    a_shift_set: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && scan.scan_code == KEY_LSHIFT) |=> flags_reg.shift)
        else $error("shift press did not set flag");

    a_caps_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && scan.scan_code == KEY_CAPS) |=> (flags_reg.caps != $past(flags_reg.caps)))
        else $error("caps press did not toggle");

    a_ctrl_space: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && xl.valid && flags_reg.ctrl && !flags_reg.shift)
            |=> (out_char_reg == CTRL_CHAR))
        else $error("ctrl press did not give a space");

endmodule

`default_nettype wire

// ===== hdl/kbd_xlate.sv =====
`default_nettype none

module kbd_xlate (
    input  kbd_pkg::scan_code_t  code,
    input  kbd_pkg::kbd_flags_t  flags,
    output kbd_pkg::kbd_flags_t  flags_next,
    output kbd_pkg::kbd_result_t result
);
    import kbd_pkg::*;

    logic   upper;
    ascii_t c;

    assign upper = flags.caps ^ flags.shift;

    always_comb
    begin
        flags_next   = flags;
        result.valid = 1'b0;
        c            = FILL_CHAR;
        if ((code & KEY_RELEASE_BIT) != '0)
        begin
            if (code == (KEY_LCTRL | KEY_RELEASE_BIT))
                flags_next.ctrl = 1'b0;
            if (code == (KEY_LSHIFT | KEY_RELEASE_BIT))
                flags_next.shift = 1'b0;
        end
        else
        begin
            case (code)
                KEY_LCTRL:  flags_next.ctrl  = 1'b1;
                KEY_LSHIFT: flags_next.shift = 1'b1;
                KEY_CAPS:   flags_next.caps  = ~flags.caps;
                KEY_LALT:   ;
                default:
                begin
                    result.valid = 1'b1;
                    if (flags.shift)
                        c = shift_char(code[6:0]);
                    else if (flags.ctrl)
                        c = CTRL_CHAR;
                    else
                        c = plain_char(code[6:0]);
                end
            endcase
        end
        if (upper && !(!flags.shift && flags.ctrl) && c >= LOWER_A && c <= LOWER_Z)
            result.ch = c - CASE_DELTA;
        else
            result.ch = c;
    end

endmodule

`default_nettype wire
